>>> src/ecrypt_pkg.sv
// Shared types and constants of the ElGamal crypto engine.
package ecrypt_pkg;

	localparam int unsigned DATA_W = 32;

	typedef enum logic [1:0] {
		MODE_ENCRYPT = 2'd0,
		MODE_DECRYPT = 2'd1,
		MODE_SIGN    = 2'd2,
		MODE_VERIFY  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_MODULUS     = 2'd0,
		REG_GENERATOR   = 2'd1,
		REG_PUBLIC_KEY  = 2'd2,
		REG_PRIVATE_KEY = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [DATA_W-1:0] message;
		logic [DATA_W-1:0] nonce;
		logic [DATA_W-1:0] first_in;
		logic [DATA_W-1:0] second_in;
	} in_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] first_out;
		logic [DATA_W-1:0] second_out;
		logic              signature_ok;
		logic              nonce_error;
	} out_item_t;

endpackage

>>> src/elgamal_crypto_engine_core.sv
// ElGamal encrypt, decrypt, sign and verify engine with a bit-serial modular multiplier.
//
//  channel | signals                             | direction
//  input   | in_valid, in_stall, in_item         | item in, stall out
//  output  | out_valid, out_stall, out_item      | item out, stall in
//  config  | cfg_we, cfg_index, cfg_data         | register write in
//
// One shared modular multiplier takes one bit of its second operand per cycle.
// An exponentiation costs up to 64 products; the shortest items have zero
// exponents, and verify, with three powers, is longest; sign adds an extended
// Euclid of up to about 47 divide/multiply rounds.
// arst_n clears control state. An item is taken only when the engine is idle;
// a finished result waits in the output register while the next item runs.
module elgamal_crypto_engine_core #(
	parameter int unsigned MOD_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  ecrypt_pkg::in_item_t                in_item,
	output logic                                out_valid,
	input  logic                                out_stall,
	output ecrypt_pkg::out_item_t               out_item,
	input  logic                                cfg_we,
	input  ecrypt_pkg::reg_idx_t                cfg_index,
	input  logic [ecrypt_pkg::DATA_W-1:0]       cfg_data
);

	localparam int unsigned DW  = ecrypt_pkg::DATA_W;
	localparam int unsigned W   = MOD_WIDTH;
	localparam int unsigned CW  = $clog2(DW + 1);

	typedef enum logic [5:0] {
		S_IDLE, S_MUL,
		S_PW_INIT, S_PW_LOOP, S_PW_MA, S_PW_SQ, S_PW_SB,
		S_E0, S_E1, S_E2, S_E3, S_E4,
		S_D0, S_D1, S_D2, S_D3, S_D4,
		S_G0, S_G1, S_G2, S_G3, S_G4, S_G5, S_G6, S_G7, S_G8, S_G9, S_G10, S_G11,
		S_V0, S_V1, S_V2, S_V3, S_V4,
		S_OUT
	} state_t;

	state_t st_q, ret_q, pw_ret_q;

	logic [DW-1:0] modulus_q, generator_q, public_key_q, private_key_q;
	logic [DW-1:0] msg_q, nonce_q, fin_q, sin_q;

	// multiplier
	logic [W-1:0]  mm_a_q, mm_m_q, mm_acc_q;
	logic [DW-1:0] mm_b_q, mm_quo_q;
	logic [CW-1:0] mm_cnt_q;

	// exponentiation
	logic [W-1:0]  pw_base_q, pw_acc_q;
	logic [DW-1:0] pw_exp_q;

	// temporaries and Euclid
	logic [W-1:0] t0_q, t1_q, t2_q, o0_q, o1_q;
	logic [W-1:0] r0_q, r1_q, s0_q, s1_q;
	logic         ok_q, err_q;

	logic             out_valid_q;
	ecrypt_pkg::out_item_t out_q;

	logic [W-1:0] pe, ne, pm2;
	logic [W:0]   dbl, sum;
	logic [W-1:0] t1s, t2s, s_new, dsub;
	logic         sub1, sub2;

	always_comb begin
		pe  = (modulus_q[W-1:0] < W'(3)) ? W'(3) : modulus_q[W-1:0];
		ne  = pe - W'(1);
		pm2 = pe - W'(2);
		dbl  = {mm_acc_q, 1'b0};
		sub1 = dbl >= {1'b0, mm_m_q};
		t1s  = sub1 ? W'(dbl - {1'b0, mm_m_q}) : W'(dbl);
		sum  = {1'b0, t1s} + (mm_b_q[DW-1] ? {1'b0, mm_a_q} : '0);
		sub2 = sum >= {1'b0, mm_m_q};
		t2s  = sub2 ? W'(sum - {1'b0, mm_m_q}) : W'(sum);
		s_new = (s0_q >= mm_acc_q) ? (s0_q - mm_acc_q) : (s0_q + ne - mm_acc_q);
		dsub  = (mm_acc_q >= t2_q) ? (mm_acc_q - t2_q) : (mm_acc_q + ne - t2_q);
	end

	assign in_stall  = (st_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q     <= DW'(3);
			generator_q   <= DW'(2);
			public_key_q  <= DW'(1);
			private_key_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ecrypt_pkg::REG_MODULUS:     modulus_q     <= cfg_data;
				ecrypt_pkg::REG_GENERATOR:   generator_q   <= cfg_data;
				ecrypt_pkg::REG_PUBLIC_KEY:  public_key_q  <= cfg_data;
				ecrypt_pkg::REG_PRIVATE_KEY: private_key_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			ret_q       <= S_IDLE;
			pw_ret_q    <= S_IDLE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			msg_q <= '0; nonce_q <= '0; fin_q <= '0; sin_q <= '0;
			mm_a_q <= '0; mm_m_q <= W'(3); mm_acc_q <= '0;
			mm_b_q <= '0; mm_quo_q <= '0; mm_cnt_q <= '0;
			pw_base_q <= '0; pw_acc_q <= '0; pw_exp_q <= '0;
			t0_q <= '0; t1_q <= '0; t2_q <= '0; o0_q <= '0; o1_q <= '0;
			r0_q <= '0; r1_q <= '0; s0_q <= '0; s1_q <= '0;
			ok_q <= 1'b0; err_q <= 1'b0;
		end else begin
			// drop the output item once taken, unless a new one replaces it
			if (out_valid_q && !out_stall && st_q != S_OUT)
				out_valid_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						msg_q   <= in_item.message;
						nonce_q <= in_item.nonce;
						fin_q   <= in_item.first_in;
						sin_q   <= in_item.second_in;
						o0_q <= '0; o1_q <= '0; ok_q <= 1'b0; err_q <= 1'b0;
						case (ecrypt_pkg::mode_t'(in_item.mode))
							ecrypt_pkg::MODE_ENCRYPT: st_q <= S_E0;
							ecrypt_pkg::MODE_DECRYPT: st_q <= S_D0;
							ecrypt_pkg::MODE_SIGN:    st_q <= S_G0;
							default:                  st_q <= S_V0;
						endcase
					end
				end
				S_MUL: begin
					// one bit of b per cycle: double, then add a, both mod m
					mm_acc_q <= t2s;
					mm_quo_q <= {mm_quo_q[DW-2:0], sub1 | sub2};
					mm_b_q   <= {mm_b_q[DW-2:0], 1'b0};
					mm_cnt_q <= mm_cnt_q - CW'(1);
					if (mm_cnt_q == CW'(1))
						st_q <= ret_q;
				end
				S_PW_INIT: begin
					pw_base_q <= mm_acc_q;
					pw_acc_q  <= W'(1);
					st_q      <= S_PW_LOOP;
				end
				S_PW_LOOP: begin
					if (pw_exp_q == '0) begin
						st_q <= pw_ret_q;
					end else if (pw_exp_q[0]) begin
						mm_a_q <= pw_acc_q; mm_b_q <= DW'(pw_base_q); mm_m_q <= pe;
						mm_acc_q <= '0; mm_cnt_q <= CW'(DW); ret_q <= S_PW_MA; st_q <= S_MUL;
					end else begin
						st_q <= S_PW_SQ;
					end
				end
				S_PW_MA: begin
					pw_acc_q <= mm_acc_q;
					st_q     <= S_PW_SQ;
				end
				S_PW_SQ: begin
					mm_a_q <= pw_base_q; mm_b_q <= DW'(pw_base_q); mm_m_q <= pe;
					mm_acc_q <= '0; mm_cnt_q <= CW'(DW); ret_q <= S_PW_SB; st_q <= S_MUL;
				end
				S_PW_SB: begin
					pw_base_q <= mm_acc_q;
					pw_exp_q  <= pw_exp_q >> 1;
					st_q      <= S_PW_LOOP;
				end
				// encrypt
				S_E0: begin
					mm_a_q <= W'(1); mm_b_q <= generator_q; mm_m_q <= pe; mm_acc_q <= '0;
					mm_cnt_q <= CW'(DW); ret_q <= S_PW_INIT; pw_exp_q <= nonce_q;
					pw_ret_q <= S_E1; st_q <= S_MUL;
				end
				S_E1: begin
					o0_q <= pw_acc_q;
					mm_a_q <= W'(1); mm_b_q <= public_key_q; mm_m_q <= pe; mm_acc_q <= '0;
					mm_cnt_q <= CW'(DW); ret_q <= S_PW_INIT; pw_exp_q <= nonce_q;
					pw_ret_q <= S_E2; st_q <= S_MUL;
				end
				S_E2: begin
					t0_q <= pw_acc_q;
					mm_a_q <= W'(1); mm_b_q <= msg_q; mm_m_q <= pe; mm_acc_q <= '0;
					mm_cnt_q <= CW'(DW); ret_q <= S_E3; st_q <= S_MUL;
				end
				S_E3: begin
					mm_a_q <= mm_acc_q; mm_b_q <= DW'(t0_q); mm_m_q <= pe; mm_acc_q <= '0;
					mm_cnt_q <= CW'(DW); ret_q <= S_E4; st_q <= S_MUL;
				end
				S_E4: begin
					o1_q <= mm_acc_q;
					st_q <= S_OUT;
				end
				// decrypt
				S_D0: begin
					mm_a_q <= W'(1); mm_b_q <= fin_q; mm_m_q <= pe; mm_acc_q <= '0;
					mm_cnt_q <= CW'(DW); ret_q <= S_PW_INIT; pw_exp_q <= private_key_q;
					pw_ret_q <= S_D1; st_q <= S_MUL;
				end
				S_D1: begin
					mm_a_q <= W'(1); mm_b_q <= DW'(pw_acc_q); mm_m_q <= pe; mm_acc_q <= '0;
					mm_cnt_q <= CW'(DW); ret_q <= S_PW_INIT; pw_exp_q <= DW'(pm2);
					pw_ret_q <= S_D2; st_q <= S_MUL;
				end
				S_D2: begin
					t0_q <= pw_acc_q;
					mm_a_q <= W'(1); mm_b_q <= sin_q; mm_m_q <= pe; mm_acc_q <= '0;
					mm_cnt_q <= CW'(DW); ret_q <= S_D3; st_q <= S_MUL;
				end
				S_D3: begin
					mm_a_q <= mm_acc_q; mm_b_q <= DW'(t0_q); mm_m_q <= pe; mm_acc_q <= '0;
					mm_cnt_q <= CW'(DW); ret_q <= S_D4; st_q <= S_MUL;
				end
				S_D4: begin
					o0_q <= mm_acc_q;
					st_q <= S_OUT;
				end
				// sign
				S_G0: begin
					mm_a_q <= W'(1); mm_b_q <= generator_q; mm_m_q <= pe; mm_acc_q <= '0;
					mm_cnt_q <= CW'(DW); ret_q <= S_PW_INIT; pw_exp_q <= nonce_q;
					pw_ret_q <= S_G1; st_q <= S_MUL;
				end
				S_G1: begin
					o0_q <= pw_acc_q;
					mm_a_q <= W'(1); mm_b_q <= nonce_q; mm_m_q <= ne; mm_acc_q <= '0;
					mm_cnt_q <= CW'(DW); ret_q <= S_G2; st_q <= S_MUL;
				end
				S_G2: begin
					r0_q <= mm_acc_q; r1_q <= ne; s0_q <= W'(1); s1_q <= '0;
					st_q <= S_G3;
				end
				S_G3: begin
					if (r1_q == '0) begin
						st_q <= S_G6;
					end else begin
						// divide r0 by r1: remainder in acc, quotient in quo
						mm_a_q <= W'(1); mm_b_q <= DW'(r0_q); mm_m_q <= r1_q; mm_acc_q <= '0;
						mm_cnt_q <= CW'(DW); ret_q <= S_G4; st_q <= S_MUL;
					end
				end
				S_G4: begin
					t0_q <= mm_acc_q;
					mm_a_q <= s1_q; mm_b_q <= mm_quo_q; mm_m_q <= ne; mm_acc_q <= '0;
					mm_cnt_q <= CW'(DW); ret_q <= S_G5; st_q <= S_MUL;
				end
				S_G5: begin
					s0_q <= s1_q; s1_q <= s_new;
					r0_q <= r1_q; r1_q <= t0_q;
					st_q <= S_G3;
				end
				S_G6: begin
					if (r0_q != W'(1)) begin
						err_q <= 1'b1;
						st_q  <= S_OUT;
					end else begin
						t1_q <= s0_q;
						mm_a_q <= W'(1); mm_b_q <= private_key_q; mm_m_q <= ne; mm_acc_q <= '0;
						mm_cnt_q <= CW'(DW); ret_q <= S_G7; st_q <= S_MUL;
					end
				end
				S_G7: begin
					t0_q <= mm_acc_q;
					mm_a_q <= W'(1); mm_b_q <= DW'(o0_q); mm_m_q <= ne; mm_acc_q <= '0;
					mm_cnt_q <= CW'(DW); ret_q <= S_G8; st_q <= S_MUL;
				end
				S_G8: begin
					mm_a_q <= t0_q; mm_b_q <= DW'(mm_acc_q); mm_m_q <= ne; mm_acc_q <= '0;
					mm_cnt_q <= CW'(DW); ret_q <= S_G9; st_q <= S_MUL;
				end
				S_G9: begin
					t2_q <= mm_acc_q;
					mm_a_q <= W'(1); mm_b_q <= msg_q; mm_m_q <= ne; mm_acc_q <= '0;
					mm_cnt_q <= CW'(DW); ret_q <= S_G10; st_q <= S_MUL;
				end
				S_G10: begin
					mm_a_q <= dsub; mm_b_q <= DW'(t1_q); mm_m_q <= ne; mm_acc_q <= '0;
					mm_cnt_q <= CW'(DW); ret_q <= S_G11; st_q <= S_MUL;
				end
				S_G11: begin
					o1_q <= mm_acc_q;
					st_q <= S_OUT;
				end
				// verify
				S_V0: begin
					mm_a_q <= W'(1); mm_b_q <= generator_q; mm_m_q <= pe; mm_acc_q <= '0;
					mm_cnt_q <= CW'(DW); ret_q <= S_PW_INIT; pw_exp_q <= msg_q;
					pw_ret_q <= S_V1; st_q <= S_MUL;
				end
				S_V1: begin
					t0_q <= pw_acc_q;
					mm_a_q <= W'(1); mm_b_q <= public_key_q; mm_m_q <= pe; mm_acc_q <= '0;
					mm_cnt_q <= CW'(DW); ret_q <= S_PW_INIT; pw_exp_q <= fin_q;
					pw_ret_q <= S_V2; st_q <= S_MUL;
				end
				S_V2: begin
					t1_q <= pw_acc_q;
					mm_a_q <= W'(1); mm_b_q <= fin_q; mm_m_q <= pe; mm_acc_q <= '0;
					mm_cnt_q <= CW'(DW); ret_q <= S_PW_INIT; pw_exp_q <= sin_q;
					pw_ret_q <= S_V3; st_q <= S_MUL;
				end
				S_V3: begin
					mm_a_q <= t1_q; mm_b_q <= DW'(pw_acc_q); mm_m_q <= pe; mm_acc_q <= '0;
					mm_cnt_q <= CW'(DW); ret_q <= S_V4; st_q <= S_MUL;
				end
				S_V4: begin
					ok_q <= (mm_acc_q == t0_q);
					st_q <= S_OUT;
				end
				S_OUT: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						out_q.first_out    <= DW'(o0_q);
						out_q.second_out   <= DW'(o1_q);
						out_q.signature_ok <= ok_q;
						out_q.nonce_error  <= err_q;
						out_valid_q        <= 1'b1;
						st_q               <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule
